FILE: hw/rtl/kdop_pkg.sv
// ----------------------------------------------------------------------------
// kdop_pkg
// Shared types and constants for the k-DOP bound accumulator: request codes,
// bound word type, per-item operation and result records.
// ----------------------------------------------------------------------------
package kdop_pkg;

  // bound word and projection set
  localparam int BOUND_W    = 26;
  localparam int NUM_DIRS   = 12;
  localparam int AXIS_W     = 4;
  localparam int REQ_W      = 3;
  localparam int BOUND_HI_I = 33554431;
  localparam int BOUND_LO_I = -33554432;

  typedef logic signed [BOUND_W-1:0] bound_t;
  typedef bound_t proj_arr_t [NUM_DIRS];

  // empty slab: min at the top of the bound range, max one above its bottom
  localparam bound_t EMPTY_MIN = 26'sd33554431;
  localparam bound_t EMPTY_MAX = -26'sd33554431;

  // result channel packing: slab_min, slab_max, padded to bytes
  localparam int OUT_TDATA_W = ((2 * BOUND_W + 7) / 8) * 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR   = 3'd0,
    REQ_ADD     = 3'd1,
    REQ_MERGE   = 3'd2,
    REQ_READ    = 3'd3,
    REQ_OVERLAP = 3'd4
  } req_t;

  // one item's control fields
  typedef struct packed {
    req_t              req;
    logic              set_sel;
    logic [AXIS_W-1:0] axis;
  } op_t;

  // one item's result fields
  typedef struct packed {
    bound_t slab_min;
    bound_t slab_max;
    logic   overlap;
  } res_t;

endpackage

FILE: hw/rtl/kdop_proj.sv
// ----------------------------------------------------------------------------
// kdop_proj
// Projects one vertex onto the twelve k-DOP directions, each sum saturated
// to the bound word range.
// ----------------------------------------------------------------------------
module kdop_proj #(
  parameter int COORD_WIDTH = 24
) (
  input  logic signed [COORD_WIDTH-1:0] x_coord,
  input  logic signed [COORD_WIDTH-1:0] y_coord,
  input  logic signed [COORD_WIDTH-1:0] z_coord,
  output kdop_pkg::proj_arr_t           proj_o
);
  import kdop_pkg::*;

  // sum width: two guard bits over a coordinate, never below the bound word
  localparam int SW = (COORD_WIDTH + 2 > BOUND_W) ? COORD_WIDTH + 2 : BOUND_W;
  localparam logic signed [SW-1:0] SAT_HI = SW'(BOUND_HI_I);
  localparam logic signed [SW-1:0] SAT_LO = SW'(BOUND_LO_I);

  logic signed [SW-1:0] xs, ys, zs;
  logic signed [SW-1:0] sum [NUM_DIRS];

  function automatic bound_t sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] c;
    begin
      if (v > SAT_HI) begin
        c = SAT_HI;
      end else if (v < SAT_LO) begin
        c = SAT_LO;
      end else begin
        c = v;
      end
      sat = c[BOUND_W-1:0];
    end
  endfunction

  // sign extend coordinates to the sum width
  assign xs = {{(SW-COORD_WIDTH){x_coord[COORD_WIDTH-1]}}, x_coord};
  assign ys = {{(SW-COORD_WIDTH){y_coord[COORD_WIDTH-1]}}, y_coord};
  assign zs = {{(SW-COORD_WIDTH){z_coord[COORD_WIDTH-1]}}, z_coord};

  // direction sums: x, y, z, x+y, x+z, y+z, x-y, x-z, y-z, x+y-z, x+z-y, y+z-x
  always_comb begin
    sum[0]  = xs;
    sum[1]  = ys;
    sum[2]  = zs;
    sum[3]  = xs + ys;
    sum[4]  = xs + zs;
    sum[5]  = ys + zs;
    sum[6]  = xs - ys;
    sum[7]  = xs - zs;
    sum[8]  = ys - zs;
    sum[9]  = xs + ys - zs;
    sum[10] = xs + zs - ys;
    sum[11] = ys + zs - xs;
  end

  always_comb begin
    for (int i = 0; i < NUM_DIRS; i++) begin
      proj_o[i] = sat(sum[i]);
    end
  end

endmodule

FILE: hw/rtl/kdop_slab_bank.sv
// ----------------------------------------------------------------------------
// kdop_slab_bank
// Holds the min and max slabs of sets A and B, applies one operation per
// cycle and forms the item's result from the state before the update.
// ----------------------------------------------------------------------------
module kdop_slab_bank #(
  parameter int AXES = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                op_valid,
  input  kdop_pkg::op_t       op,
  input  kdop_pkg::proj_arr_t proj,
  output kdop_pkg::res_t      res_o
);
  import kdop_pkg::*;

  localparam int AIDX_W = (AXES > 1) ? $clog2(AXES) : 1;

  bound_t min_r   [2][AXES];
  bound_t max_r   [2][AXES];
  bound_t min_nxt [2][AXES];
  bound_t max_nxt [2][AXES];

  logic sel;
  logic oth;
  logic ok;

  assign sel = op.set_sel;
  assign oth = ~op.set_sel;

  // slab updates, every used axis in parallel
  always_comb begin
    min_nxt = min_r;
    max_nxt = max_r;
    if (op_valid) begin
      unique case (op.req)
        REQ_CLEAR: begin
          for (int i = 0; i < AXES; i++) begin
            min_nxt[sel][i] = EMPTY_MIN;
            max_nxt[sel][i] = EMPTY_MAX;
          end
        end
        REQ_ADD: begin
          for (int i = 0; i < AXES; i++) begin
            if (proj[i] < min_r[sel][i]) min_nxt[sel][i] = proj[i];
            if (proj[i] > max_r[sel][i]) max_nxt[sel][i] = proj[i];
          end
        end
        REQ_MERGE: begin
          for (int i = 0; i < AXES; i++) begin
            if (min_r[oth][i] < min_r[sel][i]) min_nxt[sel][i] = min_r[oth][i];
            if (max_r[oth][i] > max_r[sel][i]) max_nxt[sel][i] = max_r[oth][i];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < 2; s++) begin
        for (int i = 0; i < AXES; i++) begin
          min_r[s][i] <= EMPTY_MIN;
          max_r[s][i] <= EMPTY_MAX;
        end
      end
    end else begin
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
  end

  // overlap: every used axis must intersect
  always_comb begin
    ok = 1'b1;
    for (int i = 0; i < AXES; i++) begin
      if ((min_r[0][i] > max_r[1][i]) || (max_r[0][i] < min_r[1][i])) ok = 1'b0;
    end
  end

  // result fields
  always_comb begin
    res_o = '0;
    unique case (op.req)
      REQ_READ: begin
        if (op.axis < AXIS_W'(AXES)) begin
          res_o.slab_min = min_r[sel][op.axis[AIDX_W-1:0]];
          res_o.slab_max = max_r[sel][op.axis[AIDX_W-1:0]];
        end
      end
      REQ_OVERLAP: res_o.overlap = ok;
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // a cleared set reads empty on the first axis
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (op_valid && op.req == REQ_CLEAR) |=>
      (min_r[$past(op.set_sel)][0] == EMPTY_MIN &&
       max_r[$past(op.set_sel)][0] == EMPTY_MAX))
    else $error("clear did not empty the set");

  // after a merge the selected min is no larger than the other set's min
  a_merge_min: assert property (@(posedge clk) disable iff (!rst_n)
    (op_valid && op.req == REQ_MERGE) |=>
      (min_r[$past(op.set_sel)][0] <= min_r[~$past(op.set_sel)][0]))
    else $error("merge left min above other set");

  // an added vertex lies inside the widened slab
  a_add_cover: assert property (@(posedge clk) disable iff (!rst_n)
    (op_valid && op.req == REQ_ADD) |=>
      (max_r[$past(op.set_sel)][0] >= $past(proj[0]) &&
       min_r[$past(op.set_sel)][0] <= $past(proj[0])))
    else $error("added vertex outside slab");
`endif

endmodule

FILE: hw/rtl/kdop_bound_accumulate_overlap.sv
// ----------------------------------------------------------------------------
// kdop_bound_accumulate_overlap
// Two k-DOP bounding volumes with clear, add vertex, merge, axis read and
// overlap test; one result item for every input item.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)               | tuser (low bit up)
//  in_     | in  | x_coord, y_coord, z_coord, axis  | req_type, set_sel
//  out_    | out | slab_min, slab_max               | overlap_flag
//
// One item per cycle sustained while the output is not stalled; input register,
// then projections, slab compare and result register.
// The slab registers are read and written in the same stage, so each item
// sees every earlier item's update with no bubble.
// Reset empties both sets at once; no clearing pass.
// A stalled result holds the input stage; the input register keeps taking
// items while the result register is free or being taken.
// ----------------------------------------------------------------------------
module kdop_bound_accumulate_overlap #(
  parameter int DOP_K       = 24,
  parameter int COORD_WIDTH = 24
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // x_coord, y_coord, z_coord, axis_index, zero pad
  input  logic [((3*COORD_WIDTH+4+7)/8)*8-1:0]    in_tdata,
  // req_type, set_sel
  input  logic [3:0]                              in_tuser,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // slab_min, slab_max, zero pad
  output logic [kdop_pkg::OUT_TDATA_W-1:0]        out_tdata,
  // overlap_flag
  output logic                                    out_tuser,
  output logic                                    out_tvalid,
  input  logic                                    out_tready
);
  import kdop_pkg::*;

  localparam int AXES   = (DOP_K / 2 > NUM_DIRS) ? NUM_DIRS : DOP_K / 2;
  localparam int CW     = COORD_WIDTH;

  // input stage
  logic                 s1_valid_r;
  op_t                  s1_op_r;
  logic signed [CW-1:0] s1_x_r, s1_y_r, s1_z_r;
  logic                 s1_adv;
  logic                 in_acc;

  // result stage
  logic                 out_valid_r;
  res_t                 out_res_r;
  res_t                 res;
  proj_arr_t            proj;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r.req     <= req_t'(in_tuser[REQ_W-1:0]);
      s1_op_r.set_sel <= in_tuser[REQ_W];
      s1_op_r.axis    <= in_tdata[3*CW +: AXIS_W];
      s1_x_r          <= in_tdata[0 +: CW];
      s1_y_r          <= in_tdata[CW +: CW];
      s1_z_r          <= in_tdata[2*CW +: CW];
    end
  end

  kdop_proj #(
    .COORD_WIDTH (CW)
  ) u_proj (
    .x_coord (s1_x_r),
    .y_coord (s1_y_r),
    .z_coord (s1_z_r),
    .proj_o  (proj)
  );

  kdop_slab_bank #(
    .AXES (AXES)
  ) u_bank (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (s1_adv),
    .op       (s1_op_r),
    .proj     (proj),
    .res_o    (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.overlap;
  assign out_tdata  = {{(OUT_TDATA_W - 2*BOUND_W){1'b0}},
                       out_res_r.slab_max, out_res_r.slab_min};

`ifndef NO_ASSERTIONS
  // an item leaving the input stage lands in the result register
  a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced item missing from result register");

  // an overlap result carries zero slab fields
  a_ovl_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.overlap) |->
      (out_res_r.slab_min == '0 && out_res_r.slab_max == '0))
    else $error("overlap result with slab data");

  // a blocked input stage keeps its item
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_op_r)))
    else $error("input stage lost item under stall");
`endif

endmodule

FILE: dv/tb_kdop_bound_accumulate_overlap.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_kdop_bound_accumulate_overlap
// Self-checking bench for the two-set k-DOP bound accumulator. A directed
// table walks reset state, coordinate extremes, every request, spare codes,
// empty sets and out-of-range axes; then random requests follow, vertex adds
// the largest share, clustered per set so that overlap answers go both ways.
// Every result item is checked against a typed value or a bench-side slab
// model, with bursty input traffic and a patterned output stall.
// ----------------------------------------------------------------------------
module tb_kdop_bound_accumulate_overlap;
  import kdop_pkg::*;

  localparam int TB_DOP_K      = 24;
  localparam int TB_COORD_W    = 24;
  localparam int AXES_USED     = (TB_DOP_K / 2 > NUM_DIRS) ? NUM_DIRS : TB_DOP_K / 2;
  localparam int IN_TDATA_W    = ((3 * TB_COORD_W + 4 + 7) / 8) * 8;
  localparam int RANDOM_ITEMS  = 700;
  localparam int IDLE_LIMIT    = 2000;
  localparam int TAIL_CYCLES   = 8;

  // spare request codes, no effect on state
  localparam logic [REQ_W-1:0] REQ_SPARE5 = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE7 = 3'd7;

  localparam logic        SET_A   = 1'b0;
  localparam logic        SET_B   = 1'b1;
  localparam logic signed [23:0] C_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] C_MIN = -24'sh800000;

  typedef struct {
    logic [REQ_W-1:0]  req;
    logic              sel;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic [AXIS_W-1:0] axis;
  } request_t;

  typedef struct {
    request_t rq;
    bit       fixed;   // expected result typed in the row
    res_t     want;
  } table_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  // req_type, set_sel
  logic [3:0]            in_tuser = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // slab_min, slab_max, zero pad
  logic [OUT_TDATA_W-1:0] out_tdata;
  // overlap_flag
  logic                  out_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;

  // bench copy of the slabs
  bound_t slab_lo [2][NUM_DIRS];
  bound_t slab_hi [2][NUM_DIRS];

  res_t       expected_q [$];
  table_row_t dir_rows [$];
  int         fails = 0;
  int         idle_cycles = 0;

  // per-set cluster centres for random vertices
  logic signed [23:0] centre [2][3];

  kdop_bound_accumulate_overlap #(
    .DOP_K       (TB_DOP_K),
    .COORD_WIDTH (TB_COORD_W)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // projection of a vertex on one direction, saturated to the bound word
  function automatic bound_t project(logic signed [23:0] x, logic signed [23:0] y,
                                     logic signed [23:0] z, int dir);
    longint sx, sy, sz, v;
    sx = x;
    sy = y;
    sz = z;
    case (dir)
      0:  v = sx;
      1:  v = sy;
      2:  v = sz;
      3:  v = sx + sy;
      4:  v = sx + sz;
      5:  v = sy + sz;
      6:  v = sx - sy;
      7:  v = sx - sz;
      8:  v = sy - sz;
      9:  v = sx + sy - sz;
      10: v = sx + sz - sy;
      default: v = sy + sz - sx;
    endcase
    if (v > BOUND_HI_I) v = BOUND_HI_I;
    else if (v < BOUND_LO_I) v = BOUND_LO_I;
    project = v[BOUND_W-1:0];
  endfunction

  function automatic void empty_set(int s);
    for (int d = 0; d < NUM_DIRS; d++) begin
      slab_lo[s][d] = EMPTY_MIN;
      slab_hi[s][d] = EMPTY_MAX;
    end
  endfunction

  // update the slabs for one request and return its result item
  function automatic res_t apply_request(request_t rq);
    res_t   r;
    int     s, o;
    bound_t p;
    logic   ok;
    r  = '0;
    s  = rq.sel;
    o  = s ^ 1;
    ok = 1'b1;
    case (rq.req)
      REQ_CLEAR: empty_set(s);
      REQ_ADD: begin
        for (int d = 0; d < AXES_USED; d++) begin
          p = project(rq.x, rq.y, rq.z, d);
          if (p > slab_hi[s][d]) slab_hi[s][d] = p;
          if (p < slab_lo[s][d]) slab_lo[s][d] = p;
        end
      end
      REQ_MERGE: begin
        for (int d = 0; d < AXES_USED; d++) begin
          if (slab_lo[o][d] < slab_lo[s][d]) slab_lo[s][d] = slab_lo[o][d];
          if (slab_hi[o][d] > slab_hi[s][d]) slab_hi[s][d] = slab_hi[o][d];
        end
      end
      REQ_READ: begin
        if (rq.axis < AXES_USED) begin
          r.slab_min = slab_lo[s][rq.axis];
          r.slab_max = slab_hi[s][rq.axis];
        end
      end
      REQ_OVERLAP: begin
        for (int d = 0; d < AXES_USED; d++)
          if (slab_lo[0][d] > slab_hi[1][d] || slab_hi[0][d] < slab_lo[1][d]) ok = 1'b0;
        r.overlap = ok;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic table_row_t mk_row(logic [REQ_W-1:0] req, logic sel,
                                        logic signed [23:0] x, logic signed [23:0] y,
                                        logic signed [23:0] z, logic [AXIS_W-1:0] axis,
                                        bit fixed, bound_t wmin, bound_t wmax, logic wflag);
    table_row_t t;
    t.rq.req   = req;
    t.rq.sel   = sel;
    t.rq.x     = x;
    t.rq.y     = y;
    t.rq.z     = z;
    t.rq.axis  = axis;
    t.fixed    = fixed;
    t.want.slab_min = wmin;
    t.want.slab_max = wmax;
    t.want.overlap  = wflag;
    return t;
  endfunction

  // random coordinate: mostly near the set's centre, some full range, some extremes
  function automatic logic signed [23:0] rand_coord(int s, int c);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return centre[s][c] + $signed(24'($urandom_range(0, 8191))) - 24'sd4096;
    if (pick < 88) return 24'($urandom);
    case ($urandom_range(0, 3))
      0: return C_MAX;
      1: return C_MIN;
      2: return 24'sd0;
      default: return -24'sd1;
    endcase
  endfunction

  function automatic request_t rand_request();
    request_t rq;
    int       pick;
    pick    = $urandom_range(0, 99);
    rq.sel  = 1'($urandom);
    rq.axis = 4'($urandom);
    if (pick < 42)      rq.req = REQ_ADD;
    else if (pick < 66) rq.req = REQ_READ;
    else if (pick < 79) rq.req = REQ_OVERLAP;
    else if (pick < 88) rq.req = REQ_MERGE;
    else if (pick < 96) rq.req = REQ_CLEAR;
    else                rq.req = 3'($urandom_range(REQ_SPARE5, REQ_SPARE7));
    // a cleared set gets a fresh centre, often shared with the other set
    if (rq.req == REQ_CLEAR) begin
      for (int c = 0; c < 3; c++)
        centre[rq.sel][c] = ($urandom_range(0, 1) == 0) ? centre[rq.sel ^ 1][c]
                          : $signed(24'($urandom_range(0, 24'h7FFFFF))) - 24'sh400000;
    end
    if (rq.req == REQ_READ && $urandom_range(0, 9) < 8)
      rq.axis = 4'($urandom_range(0, AXES_USED - 1));
    rq.x = rand_coord(rq.sel, 0);
    rq.y = rand_coord(rq.sel, 1);
    rq.z = rand_coord(rq.sel, 2);
    return rq;
  endfunction

  // drive one request and wait for its acceptance
  task automatic send_request(request_t rq, bit fixed, res_t want);
    res_t pred;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - 3 * TB_COORD_W - AXIS_W){1'b0}}, rq.axis, rq.z, rq.y, rq.x};
    in_tuser  <= {rq.sel, rq.req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = apply_request(rq);
    expected_q.push_back(fixed ? want : pred);
  endtask

  // bursts of items with random gaps between them
  int burst_left = 0;
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // stimulus and end of run
  initial begin
    table_row_t row;
    request_t   rq;
    empty_set(0);
    empty_set(1);
    for (int c = 0; c < 3; c++) begin
      centre[0][c] = 24'sd0;
      centre[1][c] = 24'sd0;
    end

    dir_rows.push_back(mk_row(REQ_READ, SET_A, 0, 0, 0, 4'd0, 1, EMPTY_MIN, EMPTY_MAX, 0));
    dir_rows.push_back(mk_row(REQ_READ, SET_B, 0, 0, 0, 4'd11, 1, EMPTY_MIN, EMPTY_MAX, 0));
    // two empty sets never overlap
    dir_rows.push_back(mk_row(REQ_OVERLAP, SET_A, 0, 0, 0, 4'd0, 1, '0, '0, 0));
    // axis beyond the used directions reads zero
    dir_rows.push_back(mk_row(REQ_READ, SET_A, 0, 0, 0, 4'd15, 1, '0, '0, 0));
    dir_rows.push_back(mk_row(REQ_ADD, SET_A, C_MAX, C_MAX, C_MAX, 4'd3, 0, '0, '0, 0));
    dir_rows.push_back(mk_row(REQ_ADD, SET_A, C_MIN, C_MIN, C_MIN, 4'd9, 0, '0, '0, 0));
    dir_rows.push_back(mk_row(REQ_READ, SET_A, 0, 0, 0, 4'd0, 1, -26'sd8388608,
                              26'sd8388607, 0));
    dir_rows.push_back(mk_row(REQ_ADD, SET_A, C_MAX, C_MIN, C_MIN, 4'd0, 0, '0, '0, 0));
    dir_rows.push_back(mk_row(REQ_ADD, SET_A, C_MIN, C_MAX, C_MAX, 4'd0, 0, '0, '0, 0));
    dir_rows.push_back(mk_row(REQ_READ, SET_A, 0, 0, 0, 4'd9, 0, '0, '0, 0));
    dir_rows.push_back(mk_row(REQ_READ, SET_A, 0, 0, 0, 4'd10, 0, '0, '0, 0));
    dir_rows.push_back(mk_row(REQ_READ, SET_A, 0, 0, 0, 4'd11, 0, '0, '0, 0));
    // spare codes: no effect, all fields zero
    dir_rows.push_back(mk_row(REQ_SPARE5, SET_A, -24'sd1, -24'sd1, -24'sd1, 4'd15, 1,
                              '0, '0, 0));
    dir_rows.push_back(mk_row(REQ_SPARE6, SET_B, C_MAX, C_MIN, -24'sd1, 4'd3, 1, '0, '0, 0));
    dir_rows.push_back(mk_row(REQ_SPARE7, SET_B, C_MIN, C_MAX, 24'sd0, 4'd1, 1, '0, '0, 0));
    dir_rows.push_back(mk_row(REQ_ADD, SET_B, 24'sd0, 24'sd0, 24'sd0, 4'd0, 0, '0, '0, 0));
    // set_sel has no say in the overlap test
    dir_rows.push_back(mk_row(REQ_OVERLAP, SET_B, 0, 0, 0, 4'd7, 0, '0, '0, 0));
    dir_rows.push_back(mk_row(REQ_ADD, SET_B, -24'sd1, 24'sd256, -24'sd512, 4'd0, 0,
                              '0, '0, 0));
    dir_rows.push_back(mk_row(REQ_MERGE, SET_B, 0, 0, 0, 4'd0, 0, '0, '0, 0));
    dir_rows.push_back(mk_row(REQ_READ, SET_B, 0, 0, 0, 4'd3, 0, '0, '0, 0));
    dir_rows.push_back(mk_row(REQ_CLEAR, SET_A, 0, 0, 0, 4'd0, 0, '0, '0, 0));
    dir_rows.push_back(mk_row(REQ_READ, SET_A, 0, 0, 0, 4'd5, 1, EMPTY_MIN, EMPTY_MAX, 0));
    dir_rows.push_back(mk_row(REQ_OVERLAP, SET_A, 0, 0, 0, 4'd0, 1, '0, '0, 0));
    // merge into an empty set copies the other set
    dir_rows.push_back(mk_row(REQ_MERGE, SET_A, 0, 0, 0, 4'd0, 0, '0, '0, 0));
    dir_rows.push_back(mk_row(REQ_READ, SET_A, 0, 0, 0, 4'd8, 0, '0, '0, 0));
    // merging an empty set changes nothing
    dir_rows.push_back(mk_row(REQ_CLEAR, SET_B, 0, 0, 0, 4'd0, 0, '0, '0, 0));
    dir_rows.push_back(mk_row(REQ_MERGE, SET_A, 0, 0, 0, 4'd0, 0, '0, '0, 0));
    dir_rows.push_back(mk_row(REQ_READ, SET_A, 0, 0, 0, 4'd6, 0, '0, '0, 0));
    dir_rows.push_back(mk_row(REQ_READ, SET_B, 0, 0, 0, 4'd12, 1, '0, '0, 0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      pace_sender();
      send_request(row.rq, row.fixed, row.want);
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      rq = rand_request();
      pace_sender();
      send_request(rq, 0, '0);
    end
    in_tvalid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // output stall pattern: phases of free flow, light, heavy and periodic stalls
  int stall_mode = 0;
  int phase_cnt = 0;
  always @(posedge clk) begin
    if (phase_cnt == 0) stall_mode <= $urandom_range(0, 3);
    phase_cnt <= (phase_cnt == 49) ? 0 : phase_cnt + 1;
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      2:       out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= ((phase_cnt % 8) < 3);
    endcase
  end

  // result check against the oldest expectation
  res_t   want_r;
  bound_t got_min, got_max;
  logic   got_flag;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_min  = out_tdata[BOUND_W-1:0];
      got_max  = out_tdata[2*BOUND_W-1:BOUND_W];
      got_flag = out_tuser;
      if (expected_q.size() == 0) begin
        $error("result item with nothing expected: slab_min %0d slab_max %0d overlap %0d",
               got_min, got_max, got_flag);
        fails++;
      end else begin
        want_r = expected_q.pop_front();
        if (got_min !== want_r.slab_min) begin
          $error("slab_min: expected %0d, got %0d", want_r.slab_min, got_min);
          fails++;
        end
        if (got_max !== want_r.slab_max) begin
          $error("slab_max: expected %0d, got %0d", want_r.slab_max, got_max);
          fails++;
        end
        if (got_flag !== want_r.overlap) begin
          $error("overlap_flag: expected %0d, got %0d", want_r.overlap, got_flag);
          fails++;
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

endmodule
